/* sv/modular_sponge_hash_320_macros.svh */
// Assertion macros of the sponge hash checker
`ifndef MODULAR_SPONGE_HASH_320_MACROS_SVH
`define MODULAR_SPONGE_HASH_320_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define MSH_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Output stalled this cycle implies the given condition next cycle
`define MSH_CHECK_HOLD(lbl, cond, msg) \
	`MSH_CHECK(lbl, (m_tvalid && !m_tready) |=> (cond), msg)

`endif

/* sv/msh320_pkg.sv */
// Shared types, constants and tables of the sponge hash
`default_nettype none
package msh320_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;
	localparam int unsigned NUM_LANES = 5;

	localparam logic [6:0]  FOLD1 = 7'd59;
	localparam logic [6:0]  FOLD2 = 7'd83;
	localparam logic [63:0] TRIGGER_KEY = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] SEED = 64'h0123456789ABCDEF;
	localparam logic [7:0]  PAD_BYTE = 8'h80;
	localparam logic [7:0]  EXTRA_ROUNDS_RST = 8'd8;

	localparam logic [63:0] RAW0 = SEED + 64'hDEADBEEFCAFEBABE;
	localparam logic [63:0] RAW1 = SEED ^ 64'h13198A2E03707344;
	localparam logic [63:0] RAW2 = SEED + 64'h9E3779B97F4A7C15;
	localparam logic [63:0] RAW3 = SEED ^ 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] RAW4 = SEED + 64'h94D049BB133111EB;

	// zero lanes start as 3
	localparam logic [63:0] SEED_LANE [NUM_LANES] = '{
		(RAW0 == 64'd0) ? 64'd3 : RAW0,
		(RAW1 == 64'd0) ? 64'd3 : RAW1,
		(RAW2 == 64'd0) ? 64'd3 : RAW2,
		(RAW3 == 64'd0) ? 64'd3 : RAW3,
		(RAW4 == 64'd0) ? 64'd3 : RAW4
	};

	localparam logic [8:0] PRIMES [64] = '{
		9'd3,   9'd5,   9'd7,   9'd11,  9'd13,  9'd17,  9'd19,  9'd23,
		9'd29,  9'd31,  9'd37,  9'd41,  9'd43,  9'd47,  9'd53,  9'd59,
		9'd61,  9'd67,  9'd71,  9'd73,  9'd79,  9'd83,  9'd89,  9'd97,
		9'd101, 9'd103, 9'd107, 9'd109, 9'd113, 9'd127, 9'd131, 9'd137,
		9'd139, 9'd149, 9'd151, 9'd157, 9'd163, 9'd167, 9'd173, 9'd179,
		9'd181, 9'd191, 9'd193, 9'd197, 9'd199, 9'd211, 9'd223, 9'd227,
		9'd229, 9'd233, 9'd239, 9'd241, 9'd251, 9'd257, 9'd263, 9'd269,
		9'd271, 9'd277, 9'd281, 9'd283, 9'd293, 9'd307, 9'd311, 9'd313
	};

	localparam logic KIND_ABSORB = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	// word handed from the front to the back
	typedef struct packed {
		logic        fin;
		logic [63:0] word;
	} cmd_t;

	// permutation request
	typedef struct packed {
		logic        start;
		logic        seed;
		logic [63:0] xor_word;
	} perm_req_t;

	// permutation status
	typedef struct packed {
		logic idle;
		logic done;
	} perm_stat_t;

endpackage
`default_nettype wire

/* sv/msh320_front.sv */
// Front end: accepts items and gathers bytes into words for the queue
`default_nettype none
module msh320_front
	import msh320_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // message_byte
	input  wire logic       s_tuser,   // operation
	input  wire logic       full,
	output logic            push,
	output cmd_t            push_cmd
);

	logic [55:0] partial_q;
	logic [2:0]  held_q;
	logic        acc;
	logic [63:0] byte_word;
	logic [63:0] pad_word;

	assign s_tready = !full;
	assign acc = s_tvalid && s_tready;

	// place the byte or the pad at the next free byte
	assign byte_word = {8'd0, partial_q} | ({56'd0, s_tdata} << {held_q, 3'b000});
	assign pad_word  = {8'd0, partial_q} | ({56'd0, PAD_BYTE} << {held_q, 3'b000});

	// push full words and finish requests
	always_comb begin
		push = acc && ((s_tuser == KIND_FINISH) || (held_q == 3'd7));
		push_cmd.fin  = (s_tuser == KIND_FINISH);
		push_cmd.word = (s_tuser == KIND_FINISH) ? pad_word : byte_word;
	end

	// advance the partial word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			held_q <= '0;
		end else if (acc) begin
			if (push) begin
				partial_q <= '0;
				held_q <= '0;
			end else begin
				partial_q <= byte_word[55:0];
				held_q <= held_q + 3'd1;
			end
		end
	end

endmodule
`default_nettype wire

/* sv/msh320_queue.sv */
// Short queue of words between front and back
`default_nettype none
module msh320_queue
	import msh320_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output logic      full,
	output logic      not_empty,
	output cmd_t      head
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head = mem_q[rd_q];

	// store pushed words
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* sv/msh320_perm.sv */
// Permutation engine: lane state, prime product and a shared modular multiplier
`default_nettype none
module msh320_perm
	import msh320_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire perm_req_t req,
	output perm_stat_t stat,
	output logic [63:0] lane0
);

	localparam logic [2:0] P_IDLE  = 3'd0;
	localparam logic [2:0] P_QMUL  = 3'd1;
	localparam logic [2:0] P_QRED  = 3'd2;
	localparam logic [2:0] P_MMUL  = 3'd3;
	localparam logic [2:0] P_RED_A = 3'd4;
	localparam logic [2:0] P_RED_B = 3'd5;
	localparam logic [2:0] P_RED_C = 3'd6;
	localparam logic [2:0] P_MIX   = 3'd7;

	logic [2:0]   state_q;
	logic         done_q;
	logic [63:0]  lanes_q [NUM_LANES];
	logic [63:0]  trig_q;
	logic [63:0]  q1_q;
	logic [63:0]  q2_q;
	logic [72:0]  qp1_q;
	logic [72:0]  qp2_q;
	logic [5:0]   bit_q;
	logic [3:0]   j_q;
	logic [1:0]   ph_q;
	logic [127:0] acc_q;
	logic [71:0]  s_q;
	logic [64:0]  t_q;
	logic [63:0]  tmp_q;

	logic [63:0]  nl [NUM_LANES];
	logic [2:0]   k;
	logic         sq;
	logic [6:0]   fold;
	logic [63:0]  op_a;
	logic [63:0]  op_b;
	logic [31:0]  a32;
	logic [31:0]  b32;
	logic [63:0]  pp;
	logic [127:0] pp_sh;
	logic [70:0]  hc;
	logic [63:0]  u;
	logic [63:0]  r;
	logic [63:0]  m;

	function automatic logic [63:0] rotr(input logic [63:0] v, input int unsigned n);
		return (v >> n) | (v << (64 - n));
	endfunction

	// reduce a product of 64 by 9 bits modulo 2^64 - c
	function automatic logic [63:0] red_small(input logic [72:0] p, input logic [6:0] c);
		logic [15:0] hcs;
		logic [64:0] s;
		logic [63:0] v;
		logic [63:0] mm;
		hcs = 16'(p[72:64]) * 16'(c);
		s = {1'b0, p[63:0]} + {49'd0, hcs};
		v = s[64] ? s[63:0] + {57'd0, c} : s[63:0];
		mm = 64'd0 - {57'd0, c};
		return (v >= mm) ? v - mm : v;
	endfunction

	assign stat.idle = (state_q == P_IDLE);
	assign stat.done = done_q;
	assign lane0 = lanes_q[0];

	// lanes at the start of a permutation
	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			nl[i] = req.seed ? SEED_LANE[i] : lanes_q[i];
		end
		nl[0] = nl[0] ^ req.xor_word;
	end

	// operands of the shared multiplier
	always_comb begin
		k = j_q[3:1];
		sq = !j_q[0];
		fold = k[0] ? FOLD2 : FOLD1;
		m = 64'd0 - {57'd0, fold};
		op_a = sq ? lanes_q[k] : tmp_q;
		op_b = sq ? lanes_q[k] : (k[0] ? q2_q : q1_q);
		a32 = ph_q[0] ? op_a[63:32] : op_a[31:0];
		b32 = ph_q[1] ? op_b[63:32] : op_b[31:0];
		pp = {32'd0, a32} * {32'd0, b32};
		unique case (ph_q)
			2'd0:    pp_sh = {64'd0, pp};
			2'd3:    pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
		hc = 71'(acc_q[127:64]) * 71'(fold);
		u = t_q[64] ? t_q[63:0] + {57'd0, fold} : t_q[63:0];
		r = (u >= m) ? u - m : u;
	end

	// sequence one permutation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			done_q <= 1'b0;
			bit_q <= '0;
			j_q <= '0;
			ph_q <= '0;
		end else begin
			done_q <= (state_q == P_MIX);
			unique case (state_q)
				P_IDLE: begin
					if (req.start) begin
						bit_q <= '0;
						state_q <= P_QMUL;
					end
				end
				P_QMUL: begin
					if (trig_q[bit_q]) begin
						state_q <= P_QRED;
					end else if (bit_q == 6'd63) begin
						j_q <= '0;
						ph_q <= '0;
						state_q <= P_MMUL;
					end else begin
						bit_q <= bit_q + 6'd1;
					end
				end
				P_QRED: begin
					if (bit_q == 6'd63) begin
						j_q <= '0;
						ph_q <= '0;
						state_q <= P_MMUL;
					end else begin
						bit_q <= bit_q + 6'd1;
						state_q <= P_QMUL;
					end
				end
				P_MMUL: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd3) begin
						state_q <= P_RED_A;
					end
				end
				P_RED_A: state_q <= P_RED_B;
				P_RED_B: state_q <= P_RED_C;
				P_RED_C: begin
					if (j_q == 4'd9) begin
						state_q <= P_MIX;
					end else begin
						j_q <= j_q + 4'd1;
						ph_q <= '0;
						state_q <= P_MMUL;
					end
				end
				P_MIX: state_q <= P_IDLE;
				default: state_q <= P_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			P_IDLE: begin
				if (req.start) begin
					for (int i = 0; i < NUM_LANES; i++) begin
						lanes_q[i] <= nl[i];
					end
					trig_q <= nl[0] ^ nl[2] ^ nl[4] ^ TRIGGER_KEY;
					q1_q <= 64'd1;
					q2_q <= 64'd1;
				end
			end
			P_QMUL: begin
				qp1_q <= 73'(q1_q) * 73'(PRIMES[bit_q]);
				qp2_q <= 73'(q2_q) * 73'(PRIMES[bit_q]);
				acc_q <= '0;
			end
			P_QRED: begin
				q1_q <= red_small(qp1_q, FOLD1);
				q2_q <= red_small(qp2_q, FOLD2);
				acc_q <= '0;
			end
			P_MMUL: acc_q <= acc_q + pp_sh;
			P_RED_A: s_q <= {8'd0, acc_q[63:0]} + {1'b0, hc};
			P_RED_B: t_q <= {1'b0, s_q[63:0]} + 65'(16'(s_q[71:64]) * 16'(fold));
			P_RED_C: begin
				acc_q <= '0;
				if (sq) begin
					tmp_q <= r;
				end else begin
					lanes_q[k] <= r;
				end
			end
			P_MIX: begin
				lanes_q[0] <= lanes_q[0] ^ rotr(lanes_q[1], 17);
				lanes_q[1] <= lanes_q[1] ^ rotr(lanes_q[2], 11);
				lanes_q[2] <= lanes_q[2] ^ rotr(lanes_q[3], 19);
				lanes_q[3] <= lanes_q[3] ^ rotr(lanes_q[4], 13);
				lanes_q[4] <= lanes_q[4] ^ rotr(lanes_q[0], 23);
			end
			default: acc_q <= '0;
		endcase
	end

endmodule
`default_nettype wire

/* sv/msh320_back.sv */
// Back end: runs absorb, finish and digest output over the permutation engine
`default_nettype none
module msh320_back
	import msh320_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  extra_rounds,
	input  wire logic        cmd_valid,
	input  wire cmd_t        cmd,
	output logic             cmd_pop,
	output perm_req_t        req,
	input  wire perm_stat_t  stat,
	input  wire logic [63:0] lane0,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      out_word,
	output logic [1:0]       out_index
);

	localparam logic [2:0] B_BOOT   = 3'd0;
	localparam logic [2:0] B_BOOT_W = 3'd1;
	localparam logic [2:0] B_IDLE   = 3'd2;
	localparam logic [2:0] B_ABS_W  = 3'd3;
	localparam logic [2:0] B_FIN_W  = 3'd4;
	localparam logic [2:0] B_WORD_W = 3'd5;
	localparam logic [2:0] B_OUT    = 3'd6;

	logic [2:0]  state_q;
	logic [7:0]  rounds_q;
	logic        valid_q;
	logic [63:0] word_q;
	logic [1:0]  idx_q;
	logic        out_acc;

	assign out_valid = valid_q;
	assign out_word = word_q;
	assign out_index = idx_q;
	assign out_acc = valid_q && out_ready;

	// issue permutation requests and pop the queue
	always_comb begin
		req = '0;
		cmd_pop = 1'b0;
		unique case (state_q)
			B_BOOT: begin
				req.start = 1'b1;
				req.seed = 1'b1;
			end
			B_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					req.start = 1'b1;
					req.xor_word = cmd.word;
				end
			end
			B_FIN_W: begin
				req.start = stat.done && (rounds_q != 8'd0);
			end
			B_OUT: begin
				req.start = out_acc;
				req.seed = (idx_q == 2'd3);
			end
			default: req = '0;
		endcase
	end

	// advance the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_BOOT;
			valid_q <= 1'b0;
			rounds_q <= '0;
			idx_q <= '0;
		end else begin
			unique case (state_q)
				B_BOOT: state_q <= B_BOOT_W;
				B_BOOT_W, B_ABS_W: begin
					if (stat.done) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (cmd_valid) begin
						rounds_q <= extra_rounds;
						state_q <= (cmd.fin == KIND_FINISH) ? B_FIN_W : B_ABS_W;
					end
				end
				B_FIN_W: begin
					if (stat.done) begin
						if (rounds_q != 8'd0) begin
							rounds_q <= rounds_q - 8'd1;
						end else begin
							idx_q <= '0;
							valid_q <= 1'b1;
							state_q <= B_OUT;
						end
					end
				end
				B_WORD_W: begin
					if (stat.done) begin
						valid_q <= 1'b1;
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (out_acc) begin
						valid_q <= 1'b0;
						if (idx_q == 2'd3) begin
							state_q <= B_BOOT_W;
						end else begin
							idx_q <= idx_q + 2'd1;
							state_q <= B_WORD_W;
						end
					end
				end
				default: state_q <= B_BOOT;
			endcase
		end
	end

	// capture lane 0 for the output register
	always_ff @(posedge clk) begin
		if (stat.done && ((state_q == B_WORD_W) ||
				((state_q == B_FIN_W) && (rounds_q == 8'd0)))) begin
			word_q <= lane0;
		end
	end

endmodule
`default_nettype wire

/* sv/modular_sponge_hash_320.sv */
// Top level of the 320-bit sponge hash with an 8-byte rate
// Bytes are taken one per cycle while the word queue has room; every eighth
// byte costs one permutation (a prime product loop over the 64 trigger bits,
// ten modular multiplies and one mix step).
// A finish runs 1 + extra_rounds permutations, then four words, one permutation apart.
// Reset is asynchronous; after it one permutation of the seed lanes runs first.
`default_nettype none
module modular_sponge_hash_320
	import msh320_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,    // [7:0] message_byte
	input  wire logic        s_tuser,    // [0] operation
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata,    // [63:0] digest_word, [65:64] word_index
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata
);

	logic [7:0]  extra_rounds_q;
	logic        push;
	cmd_t        push_cmd;
	logic        full;
	logic        not_empty;
	cmd_t        head;
	logic        pop;
	perm_req_t   req;
	perm_stat_t  stat;
	logic [63:0] lane0;
	logic [63:0] out_word;
	logic [1:0]  out_index;

	// hold the round count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extra_rounds_q <= EXTRA_ROUNDS_RST;
		end else if (cfg_we) begin
			extra_rounds_q <= cfg_wdata;
		end
	end

	msh320_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	msh320_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head      (head)
	);

	msh320_perm u_perm (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.stat   (stat),
		.lane0  (lane0)
	);

	msh320_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.extra_rounds (extra_rounds_q),
		.cmd_valid    (not_empty),
		.cmd          (head),
		.cmd_pop      (pop),
		.req          (req),
		.stat         (stat),
		.lane0        (lane0),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_word     (out_word),
		.out_index    (out_index)
	);

	assign m_tdata = {6'd0, out_index, out_word};
	assign m_tlast = (out_index == 2'd3);

endmodule
`default_nettype wire

/* sv/msh320_checker.sv */
// Port-level checks of the sponge hash output stream, bound to the top level
`default_nettype none
`include "modular_sponge_hash_320_macros.svh"
module msh320_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [71:0] m_tdata,
	input wire logic        m_tlast
);

	// stalled item holds
	`MSH_CHECK_HOLD(a_out_hold, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled item changed")

	// last flag marks word three only
	`MSH_CHECK(a_last_idx, m_tvalid |-> (m_tlast == (m_tdata[65:64] == 2'd3)), "tlast mismatch")

	// fill bits stay zero
	`MSH_CHECK(a_pad_zero, m_tvalid |-> (m_tdata[71:66] == 6'd0), "fill bits set")

	// a permutation separates digest words
	`MSH_CHECK(a_gap, (m_tvalid && m_tready) |=> !m_tvalid, "words back to back")

endmodule

bind modular_sponge_hash_320 msh320_checker u_msh320_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
`default_nettype wire

/* tb/tb_modular_sponge_hash_320.sv */
// Self-checking testbench of the sponge hash: predicts digests and checks every result item
`timescale 1ns / 1ps
`default_nettype none
module tb_modular_sponge_hash_320;
	import msh320_pkg::*;

	localparam logic [63:0] MOD_A = 64'hFFFFFFFFFFFFFFC5;
	localparam logic [63:0] MOD_B = 64'hFFFFFFFFFFFFFFAD;
	localparam int SETTLE_CYCLES = 600;

	typedef struct packed {
		logic       kind;
		logic [7:0] msg_byte;
	} byte_item_t;

	typedef struct packed {
		logic [63:0] word;
		logic [1:0]  index;
		logic        last;
	} digest_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = '0;

	byte_item_t   pending_bytes[$];
	digest_item_t digest_q[$];

	// predicted sponge state and register
	logic [63:0] lane[NUM_LANES];
	logic [55:0] gathered;
	int          n_held;
	logic [7:0]  rounds_cfg;

	int errors = 0;
	int n_bytes = 0;
	int n_finish = 0;
	int n_words = 0;
	int n_cfg = 0;
	bit in_taken = 1'b0;
	bit calm = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;

	modular_sponge_hash_320 u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return 64'(p % {64'd0, m});
	endfunction

	function automatic logic [63:0] rot_right(logic [63:0] v, int k);
		return (v >> k) | (v << (64 - k));
	endfunction

	// one round of the prime-product permutation on the predicted lanes
	task automatic mix_lanes();
		logic [63:0] trig, qa, qb;
		logic [63:0] t[NUM_LANES];
		trig = lane[0] ^ lane[2] ^ lane[4] ^ TRIGGER_KEY;
		qa = 64'd1;
		qb = 64'd1;
		for (int i = 0; i < 64; i++) begin
			if (trig[i]) begin
				qa = mul_mod(qa, 64'(PRIMES[i]), MOD_A);
				qb = mul_mod(qb, 64'(PRIMES[i]), MOD_B);
			end
		end
		for (int i = 0; i < NUM_LANES; i++) begin
			if (i % 2 == 0)
				t[i] = mul_mod(mul_mod(lane[i], lane[i], MOD_A), qa, MOD_A);
			else
				t[i] = mul_mod(mul_mod(lane[i], lane[i], MOD_B), qb, MOD_B);
		end
		for (int i = 0; i < NUM_LANES; i++) begin
			case (i)
				0: lane[i] = t[0] ^ rot_right(t[1], 17);
				1: lane[i] = t[1] ^ rot_right(t[2], 11);
				2: lane[i] = t[2] ^ rot_right(t[3], 19);
				3: lane[i] = t[3] ^ rot_right(t[4], 13);
				default: lane[i] = t[4] ^ rot_right(t[0], 23);
			endcase
		end
	endtask

	task automatic restart_sponge();
		for (int i = 0; i < NUM_LANES; i++) lane[i] = SEED_LANE[i];
		gathered = '0;
		n_held = 0;
		mix_lanes();
	endtask

	// advance the predicted state by one accepted item
	task automatic predict_item(logic kind, logic [7:0] b);
		logic [63:0] word;
		digest_item_t d;
		word = {8'd0, gathered} | (64'(b) << (8 * n_held));
		if (kind == KIND_ABSORB) begin
			n_bytes++;
			if (n_held == 7) begin
				lane[0] ^= word;
				mix_lanes();
				gathered = '0;
				n_held = 0;
			end else begin
				gathered = word[55:0];
				n_held++;
			end
		end else begin
			n_finish++;
			lane[0] ^= {8'd0, gathered} | (64'(PAD_BYTE) << (8 * n_held));
			mix_lanes();
			for (int r = 0; r < rounds_cfg; r++) mix_lanes();
			for (int k = 0; k < 4; k++) begin
				if (k > 0) mix_lanes();
				d.word = lane[0];
				d.index = 2'(k);
				d.last = (k == 3);
				digest_q.push_back(d);
			end
			restart_sponge();
		end
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
	endtask

	// sample accepted items, register writes and digest words
	always @(posedge clk) begin
		digest_item_t want;
		in_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n) begin
			if (cfg_we) rounds_cfg = cfg_wdata;
			if (s_tvalid && s_tready) begin
				predict_item(s_tuser, s_tdata);
			end
			if (m_tvalid && m_tready) begin
				n_words++;
				if (digest_q.size() == 0) begin
					report("unexpected digest word", m_tdata[63:0], '0);
				end else begin
					want = digest_q.pop_front();
					if (m_tdata[63:0] !== want.word)
						report("digest_word", m_tdata[63:0], want.word);
					if (m_tdata[65:64] !== want.index)
						report("word_index", 64'(m_tdata[65:64]), 64'(want.index));
					if (m_tlast !== want.last)
						report("last_word", 64'(m_tlast), 64'(want.last));
				end
			end
		end
	end

	// drive the next byte item, with random idle bursts
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				send_gap = $urandom_range(0, 11);
				s_tvalid <= 1'b0;
			end else if (pending_bytes.size() > 0) begin
				byte_item_t it;
				it = pending_bytes.pop_front();
				s_tdata <= it.msg_byte;
				s_tuser <= it.kind;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// stall the digest output in random bursts
	always @(negedge clk) begin
		if (arst_n) begin
			if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				recv_gap = $urandom_range(0, 11);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic add_byte(logic [7:0] b);
		pending_bytes.push_back('{KIND_ABSORB, b});
	endtask

	task automatic add_finish();
		pending_bytes.push_back('{KIND_FINISH, 8'($urandom_range(0, 255))});
	endtask

	task automatic add_message(int len);
		for (int i = 0; i < len; i++) add_byte(8'($urandom_range(0, 255)));
		add_finish();
	endtask

	// hold until every item is sent and every digest word is back, then let the core settle
	task automatic drain();
		while (pending_bytes.size() > 0 || s_tvalid || digest_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_rounds(logic [7:0] v);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		n_cfg++;
	endtask

	initial begin
		rounds_cfg = EXTRA_ROUNDS_RST;
		restart_sponge();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty message, a full word of zeros, seven bytes of ones, pad-only edge cases
		add_finish();
		for (int i = 0; i < 8; i++) add_byte(8'h00);
		add_finish();
		for (int i = 0; i < 7; i++) add_byte(8'hFF);
		add_finish();
		add_byte(8'h80);
		add_finish();
		add_finish();

		// sweep the round count: minimum, maximum, one, then random settings
		write_rounds(8'd0);
		for (int i = 0; i < 6; i++) add_message($urandom_range(0, 17));
		write_rounds(8'd255);
		add_message(3);
		add_message(8);
		write_rounds(8'd1);
		for (int i = 0; i < 6; i++) add_message($urandom_range(0, 17));
		for (int p = 0; p < 3; p++) begin
			write_rounds(8'($urandom_range(2, 12)));
			for (int i = 0; i < 5; i++) add_message($urandom_range(0, 17));
		end

		// last part without any idling
		drain();
		calm = 1'b1;
		for (int i = 0; i < 4; i++) add_message($urandom_range(0, 17));
		drain();

		$display("covered %0d message bytes, %0d finishes, %0d digest words, %0d writes",
			n_bytes, n_finish, n_words, n_cfg);
		$display("round counts 0, 1, 255 and random values with random stalls on both sides");
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire

/* files.f */
+incdir+sv
sv/msh320_pkg.sv
sv/msh320_front.sv
sv/msh320_queue.sv
sv/msh320_perm.sv
sv/msh320_back.sv
sv/modular_sponge_hash_320.sv
sv/msh320_checker.sv
tb/tb_modular_sponge_hash_320.sv
